// File: design/sgdmf_pkg.sv
// Shared constants, types and saturation helpers for the SGD factor update engine.
package sgdmf_pkg;

    localparam int K_MAX_DEF = 64;
    localparam int ROWS_DEF  = 4096;
    localparam int COLS_DEF  = 4096;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam int FRAC_BITS = 24;
    localparam int PROD_W    = 66;
    localparam int WIDE_W    = 42;

    localparam logic [24:0] ONE_Q24       = 25'd16777216;
    localparam logic [24:0] LR_RESET      = 25'd16777;
    localparam logic [24:0] REGW_RESET    = 25'd838861;
    localparam logic [6:0]  RANK_RESET    = 7'd64;

    localparam logic [2:0] CMD_WR_W = 3'd0;
    localparam logic [2:0] CMD_WR_H = 3'd1;
    localparam logic [2:0] CMD_RATE = 3'd2;
    localparam logic [2:0] CMD_RD_W = 3'd3;
    localparam logic [2:0] CMD_RD_H = 3'd4;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    localparam logic [1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [1:0] REG_REG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_RANK       = 2'd2;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

    function automatic logic signed [31:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] res;
        if (v[WIDE_W-1:31] != {(WIDE_W-31){v[WIDE_W-1]}}) begin
            res = v[WIDE_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] f_sat_add(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [WIDE_W-1:0] s;
        s = WIDE_W'(a) + WIDE_W'(b);
        return f_sat32(s);
    endfunction

    function automatic logic signed [31:0] f_sat_sub(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [WIDE_W-1:0] s;
        s = WIDE_W'(a) - WIDE_W'(b);
        return f_sat32(s);
    endfunction

endpackage

// File: design/sgdmf_ram.sv
// Single-write, single-read factor memory with registered read data.
module sgdmf_ram #(
    parameter int DEPTH = sgdmf_pkg::K_MAX_DEF * sgdmf_pkg::ROWS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  sgdmf_pkg::t_ram_ctl  i_ctl,
    input  logic [AW-1:0]        i_addr,
    input  logic [31:0]          i_wdata,
    output logic [31:0]          o_rdata
);
    import sgdmf_pkg::*;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sgdmf_mul.sv
// Shared registered Q8.24 multiplier with floor truncation and 32-bit saturation.
module sgdmf_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [31:0] o_q
);
    import sgdmf_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_q = f_sat32(r_prod[PROD_W-1:FRAC_BITS]);

endmodule

// File: design/sgd_matrix_factor_update.sv
// Top level of the SGD matrix-factorization update engine: sequencer, config and output beat.
//
//  channel  | dir | handshake            | payload
//  s (item) | in  | i_s_tvalid/o_s_tready| tuser: command; tdata: row, col, elem, value
//  m (res)  | out | o_m_tvalid/i_m_tready| tuser: result_kind; tdata: result_value
//  config   | in  | psel/penable/pready  | paddr, pwdata, prdata (APB, 3 registers)
//
//  Element writes and unknown commands pass from execute to done; reads add a read-wait
//  state between them. A rating uses rank = min(rank_in_use, K_MAX), or zero when row or
//  column is out of range: the single shared multiplier issues one product per element
//  for the dot product, then a fetch, six products and a write-back per element for the
//  update.
//  Reset is synchronous; the factor memories are not cleared and hold garbage until written.
//  A result waits in the output register while the next item is accepted; a second
//  result stalls in the done state until the output beat is taken.
module sgd_matrix_factor_update #(
    parameter int K_MAX = sgdmf_pkg::K_MAX_DEF,
    parameter int ROWS  = sgdmf_pkg::ROWS_DEF,
    parameter int COLS  = sgdmf_pkg::COLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [11:0] row_addr, [23:12] col_index, [29:24] elem_index, [61:30] value, [63:62] zero
    input  logic [sgdmf_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [2:0] command
    input  logic [sgdmf_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] result_value
    output logic [sgdmf_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [1:0] result_kind
    output logic [sgdmf_pkg::M_TUSER_W-1:0]  o_m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sgdmf_pkg::PADDR_W-1:0]    paddr,
    input  logic [sgdmf_pkg::PDATA_W-1:0]    pwdata,
    output logic [sgdmf_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import sgdmf_pkg::*;

    localparam int W_DEPTH = ROWS * K_MAX;
    localparam int H_DEPTH = COLS * K_MAX;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int H_AW    = (H_DEPTH > 1) ? $clog2(H_DEPTH) : 1;
    localparam int CNT_W   = $clog2(K_MAX + 1);

    localparam logic [2:0] STEP_EH  = 3'd0;
    localparam logic [2:0] STEP_RW  = 3'd1;
    localparam logic [2:0] STEP_EW  = 3'd2;
    localparam logic [2:0] STEP_RH  = 3'd3;
    localparam logic [2:0] STEP_LGW = 3'd4;
    localparam logic [2:0] STEP_WRW = 3'd5;
    localparam logic [2:0] STEP_WRH = 3'd6;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EXEC   = 8'b0000_0010,
        ST_RDWAIT = 8'b0000_0100,
        ST_DOT    = 8'b0000_1000,
        ST_ERR    = 8'b0001_0000,
        ST_FETCH  = 8'b0010_0000,
        ST_UPD    = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [24:0] r_learn_rate;
    logic [24:0] r_reg_weight;
    logic [6:0]  r_rank_in_use;

    logic [2:0]        r_cmd;
    logic              r_row_ok, r_col_ok, r_elem_ok;
    logic [W_AW-1:0]   r_w_base;
    logic [H_AW-1:0]   r_h_base;
    logic [5:0]        r_elem;
    logic signed [31:0] r_value;

    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_rank;
    logic [2:0]        r_step, n_step;
    logic              r_v1, n_v1, r_v2;

    logic signed [31:0] r_acc, n_acc;
    logic signed [31:0] r_t, n_t;
    logic signed [31:0] r_gw, n_gw;
    logic signed [31:0] r_gh, n_gh;
    logic signed [31:0] r_err, n_err;
    logic [1:0]         r_res_kind, n_res_kind;
    logic signed [31:0] r_res_value, n_res_value;

    logic               r_m_tvalid;
    logic [1:0]         r_m_kind;
    logic [31:0]        r_m_value;

    t_ram_ctl           ctl_w, ctl_h;
    logic [W_AW-1:0]    addr_w;
    logic [H_AW-1:0]    addr_h;
    logic [31:0]        wdata_w, wdata_h;
    logic [31:0]        rd_w, rd_h;
    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] mul_q;

    logic               s_accept;
    logic               out_load;
    logic               cfg_wr;
    logic [11:0]        in_row, in_col;
    logic [5:0]         in_elem;

    assign in_row  = i_s_tdata[11:0];
    assign in_col  = i_s_tdata[23:12];
    assign in_elem = i_s_tdata[29:24];

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == ST_DONE) && (!r_m_tvalid || i_m_tready);

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate  <= LR_RESET;
            r_reg_weight  <= REGW_RESET;
            r_rank_in_use <= RANK_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LEARN_RATE: begin
                    r_learn_rate <= (pwdata[24:0] > ONE_Q24) ? ONE_Q24 : pwdata[24:0];
                end
                REG_REG_WEIGHT: begin
                    r_reg_weight <= (pwdata[24:0] > ONE_Q24) ? ONE_Q24 : pwdata[24:0];
                end
                REG_RANK: begin
                    r_rank_in_use <= pwdata[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LEARN_RATE: prdata = {7'd0, r_learn_rate};
            REG_REG_WEIGHT: prdata = {7'd0, r_reg_weight};
            REG_RANK:       prdata = {25'd0, r_rank_in_use};
            default:        prdata = '0;
        endcase
    end

    // latch the item
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_row_ok  <= int'(in_row) < ROWS;
            r_col_ok  <= int'(in_col) < COLS;
            r_elem_ok <= int'(in_elem) < K_MAX;
            r_w_base  <= W_AW'(int'(in_row) * K_MAX);
            r_h_base  <= H_AW'(int'(in_col) * K_MAX);
            r_elem    <= in_elem;
            r_value   <= $signed(i_s_tdata[61:30]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd   <= CMD_WR_W;
            r_k     <= '0;
            r_rank  <= '0;
            r_step  <= STEP_EH;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_v1    <= n_v1;
            r_v2    <= r_v1;
            if (s_accept) begin
                r_cmd <= i_s_tuser;
                r_k   <= '0;
                if ((int'(in_row) < ROWS) && (int'(in_col) < COLS)) begin
                    r_rank <= (int'(r_rank_in_use) > K_MAX) ? CNT_W'(K_MAX)
                                                            : CNT_W'(r_rank_in_use);
                end else begin
                    r_rank <= '0;
                end
            end else begin
                r_k <= n_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_t         <= n_t;
        r_gw        <= n_gw;
        r_gh        <= n_gh;
        r_err       <= n_err;
        r_res_kind  <= n_res_kind;
        r_res_value <= n_res_value;
    end

    // memory addressing
    always_comb begin
        if (r_state == ST_EXEC) begin
            addr_w = r_w_base + W_AW'(r_elem);
            addr_h = r_h_base + H_AW'(r_elem);
        end else begin
            addr_w = r_w_base + W_AW'(r_k);
            addr_h = r_h_base + H_AW'(r_k);
        end
    end

    assign wdata_w = (r_state == ST_EXEC) ? r_value : f_sat_sub($signed(rd_w), mul_q);
    assign wdata_h = (r_state == ST_EXEC) ? r_value : f_sat_sub($signed(rd_h), mul_q);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_step      = r_step;
        n_v1        = 1'b0;
        n_acc       = r_acc;
        n_t         = r_t;
        n_gw        = r_gw;
        n_gh        = r_gh;
        n_err       = r_err;
        n_res_kind  = r_res_kind;
        n_res_value = r_res_value;
        ctl_w       = '0;
        ctl_h       = '0;
        mul_a       = 33'($signed(rd_w));
        mul_b       = 33'($signed(rd_h));

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_kind  = KIND_ACK;
                n_res_value = '0;
                n_acc       = '0;
                n_state     = ST_DONE;
                case (r_cmd)
                    CMD_WR_W: begin
                        ctl_w.we = r_row_ok && r_elem_ok;
                    end
                    CMD_WR_H: begin
                        ctl_h.we = r_col_ok && r_elem_ok;
                    end
                    CMD_RD_W: begin
                        ctl_w.re   = r_row_ok && r_elem_ok;
                        n_res_kind = KIND_READ;
                        n_state    = ST_RDWAIT;
                    end
                    CMD_RD_H: begin
                        ctl_h.re   = r_col_ok && r_elem_ok;
                        n_res_kind = KIND_READ;
                        n_state    = ST_RDWAIT;
                    end
                    CMD_RATE: begin
                        n_res_kind = KIND_ERR;
                        n_state    = ST_DOT;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RDWAIT: begin
                if (r_cmd == CMD_RD_W) begin
                    n_res_value = (r_row_ok && r_elem_ok) ? $signed(rd_w) : '0;
                end else begin
                    n_res_value = (r_col_ok && r_elem_ok) ? $signed(rd_h) : '0;
                end
                n_state = ST_DONE;
            end
            ST_DOT: begin
                if (r_k < r_rank) begin
                    ctl_w.re = 1'b1;
                    ctl_h.re = 1'b1;
                    n_k      = r_k + 1'b1;
                    n_v1     = 1'b1;
                end
                if (r_v2) begin
                    n_acc = f_sat_add(r_acc, mul_q);
                end
                if ((r_k == r_rank) && !r_v1 && !r_v2) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                n_err       = f_sat_sub(r_acc, r_value);
                n_res_kind  = KIND_ERR;
                n_res_value = f_sat_sub(r_acc, r_value);
                n_k         = '0;
                n_state     = (r_rank == '0) ? ST_DONE : ST_FETCH;
            end
            ST_FETCH: begin
                ctl_w.re = 1'b1;
                ctl_h.re = 1'b1;
                n_step   = STEP_EH;
                n_state  = ST_UPD;
            end
            ST_UPD: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    STEP_EH: begin
                        mul_a = 33'(r_err);
                        mul_b = 33'($signed(rd_h));
                    end
                    STEP_RW: begin
                        mul_a = $signed({8'd0, r_reg_weight});
                        mul_b = 33'($signed(rd_w));
                        n_t   = mul_q;
                    end
                    STEP_EW: begin
                        mul_a = 33'(r_err);
                        mul_b = 33'($signed(rd_w));
                        n_gw  = f_sat_add(r_t, mul_q);
                    end
                    STEP_RH: begin
                        mul_a = $signed({8'd0, r_reg_weight});
                        mul_b = 33'($signed(rd_h));
                        n_t   = mul_q;
                    end
                    STEP_LGW: begin
                        mul_a = $signed({8'd0, r_learn_rate});
                        mul_b = 33'(r_gw);
                        n_gh  = f_sat_add(r_t, mul_q);
                    end
                    STEP_WRW: begin
                        mul_a    = $signed({8'd0, r_learn_rate});
                        mul_b    = 33'(r_gh);
                        ctl_w.we = 1'b1;
                    end
                    STEP_WRH: begin
                        ctl_h.we = 1'b1;
                        n_k      = r_k + 1'b1;
                        n_state  = (CNT_W'(r_k + 1'b1) == r_rank) ? ST_DONE : ST_FETCH;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    sgdmf_ram #(.DEPTH(W_DEPTH), .AW(W_AW)) u_w_ram (
        .i_clk   (i_clk),
        .i_ctl   (ctl_w),
        .i_addr  (addr_w),
        .i_wdata (wdata_w),
        .o_rdata (rd_w)
    );

    sgdmf_ram #(.DEPTH(H_DEPTH), .AW(H_AW)) u_h_ram (
        .i_clk   (i_clk),
        .i_ctl   (ctl_h),
        .i_addr  (addr_h),
        .i_wdata (wdata_h),
        .o_rdata (rd_h)
    );

    sgdmf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_q   (mul_q)
    );

    // output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_kind  <= r_res_kind;
            r_m_value <= r_res_value;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tuser  = r_m_kind;
    assign o_m_tdata  = r_m_value;

    a_done_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_m_tvalid)
        else $error("result not presented after done");

    a_k_in_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_k <= r_rank))
        else $error("element counter beyond rank");

    a_no_read_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (!ctl_w.re && !ctl_h.re))
        else $error("memory read during update disturbs held operands");

    a_w_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_w.we |-> ((r_state == ST_EXEC) || ((r_state == ST_UPD) && (r_step == STEP_WRW))))
        else $error("row store written outside its slot");

    a_h_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_h.we |-> ((r_state == ST_EXEC) || ((r_state == ST_UPD) && (r_step == STEP_WRH))))
        else $error("column store written outside its slot");

endmodule
